FILE: rtl/kstm_pkg.sv
`timescale 1ns / 1ps

package kstm_pkg;

  localparam int KEY_W    = 8;
  localparam int HID_W    = 8;
  localparam int STATUS_W = 3;

  localparam logic [KEY_W-1:0] WILDCARD = 8'h2A;

  // result status codes carried on the output tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_PENDING  = 3'd2,
    ST_MATCHED  = 3'd3,
    ST_NOMATCH  = 3'd4
  } status_t;

  // how the datapath closes an item
  typedef enum logic [2:0] {
    RES_NONE      = 3'd0,
    RES_FULL      = 3'd1,
    RES_INS_FOUND = 3'd2,
    RES_INS_NEW   = 3'd3,
    RES_NOMATCH   = 3'd4,
    RES_MATCH_HIT = 3'd5
  } res_t;

  typedef struct packed {
    logic capture;
    logic rd_parent;
    logic cur_from_root;
    logic cur_from_child;
    logic cur_from_sib;
    logic alloc;
    logic finish;
    res_t res;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_insert;
    logic dropping;
    logic parent_root;
    logic cur_ok;
    logic key_hit;
    logic has_room;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/key_sequence_trie_matcher_top.sv
`timescale 1ns / 1ps

// Trie matcher for key sequences.
// Input stream: one request per item. s_tuser selects the operation (0 insert a
// sequence character, 1 match a key), s_tlast marks the final character of an
// inserted sequence, s_tdata carries the character and the handler id.
// Output stream: exactly one result per request, in request order. m_tuser
// carries the status (inserted, table full, match pending, matched, no match),
// m_tdata the matched handler and the completing character, both zero
// unless the status is matched.
// Requests are handled one at a time: a request walks the children of its
// parent one sibling at a time through the single-port node tables, reading
// the parent's first child when the parent is not the root and passing
// through the alloc and link states when a node is added. The result becomes
// valid in the same cycle that the next request can be taken.
// Results go through an output register, so a new request is taken while the
// previous result waits; when the receiver stalls, the block holds the next
// result internally and stops taking requests until the register frees.
// Reset empties the trie to the root alone, returns both cursors to the root
// and clears the drop flag; no clearing pass is needed.
module key_sequence_trie_matcher_top #(
  parameter int NODE_COUNT    = 64,
  parameter int HANDLER_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // key_char [7:0], handler_id [15:8]
  input  logic        s_tuser,   // func
  input  logic        s_tlast,   // last_of_sequence
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // matched_handler [7:0], final_char [15:8]
  output logic [2:0]  m_tuser    // status
);

  kstm_pkg::cmd_t  cmd;
  kstm_pkg::stat_t stat;

  kstm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kstm_datapath #(
    .NODE_COUNT    (NODE_COUNT),
    .HANDLER_COUNT (HANDLER_COUNT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_func  (s_tuser),
    .in_key   (s_tdata[7:0]),
    .in_hid   (s_tdata[15:8]),
    .in_last  (s_tlast),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: rtl/kstm_ctrl.sv
`timescale 1ns / 1ps

module kstm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  kstm_pkg::stat_t  stat,
  output kstm_pkg::cmd_t   cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_START = 8'b0000_0010,
    S_CHILD = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_CMP   = 8'b0001_0000,
    S_ALLOC = 8'b0010_0000,
    S_LINK  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // take no request while reset is held
  assign s_tready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.res    = kstm_pkg::RES_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_START;
        end
      end
      S_START: begin
        if (stat.is_insert && stat.dropping) begin
          cmd.finish = 1'b1;
          cmd.res    = kstm_pkg::RES_FULL;
          state_next = S_OUT;
        end else if (stat.parent_root) begin
          cmd.cur_from_root = 1'b1;
          state_next        = S_CHECK;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = S_CHILD;
        end
      end
      S_CHILD: begin
        cmd.cur_from_child = 1'b1;
        state_next         = S_CHECK;
      end
      S_CHECK: begin
        if (stat.cur_ok) begin
          state_next = S_CMP;
        end else if (!stat.is_insert) begin
          cmd.finish = 1'b1;
          cmd.res    = kstm_pkg::RES_NOMATCH;
          state_next = S_OUT;
        end else if (stat.has_room) begin
          state_next = S_ALLOC;
        end else begin
          cmd.finish = 1'b1;
          cmd.res    = kstm_pkg::RES_FULL;
          state_next = S_OUT;
        end
      end
      S_CMP: begin
        if (stat.key_hit) begin
          cmd.finish = 1'b1;
          cmd.res    = stat.is_insert ? kstm_pkg::RES_INS_FOUND : kstm_pkg::RES_MATCH_HIT;
          state_next = S_OUT;
        end else begin
          cmd.cur_from_sib = 1'b1;
          state_next       = S_CHECK;
        end
      end
      S_ALLOC: begin
        cmd.alloc  = 1'b1;
        state_next = S_LINK;
      end
      S_LINK: begin
        cmd.finish = 1'b1;
        cmd.res    = kstm_pkg::RES_INS_NEW;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/kstm_datapath.sv
`timescale 1ns / 1ps

module kstm_datapath #(
  parameter int NODE_COUNT    = 64,
  parameter int HANDLER_COUNT = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_func,
  input  logic [kstm_pkg::KEY_W-1:0]    in_key,
  input  logic [kstm_pkg::HID_W-1:0]    in_hid,
  input  logic                          in_last,
  input  kstm_pkg::cmd_t                cmd,
  output kstm_pkg::stat_t               stat,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,
  output logic [kstm_pkg::STATUS_W-1:0] m_tuser
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int HW = (HANDLER_COUNT >= 256) ? kstm_pkg::HID_W : $clog2(HANDLER_COUNT);
  localparam logic [AW:0] NODE_LIMIT = (AW + 1)'(NODE_COUNT);

  // captured request
  logic                       func_r;
  logic                       last_r;
  logic [kstm_pkg::KEY_W-1:0] key_r;
  logic [kstm_pkg::HID_W-1:0] hid_r;
  logic [HW-1:0]              hid_mod;

  // trie control state
  logic [AW:0]   nodes_used;
  logic [AW-1:0] ins_cur;
  logic [AW-1:0] mat_cur;
  logic          dropping;
  logic [AW-1:0] root_child;

  // walk registers
  logic [AW-1:0] cur;
  logic [AW-1:0] tail;

  // node tables
  logic [kstm_pkg::KEY_W-1:0] key_mem   [NODE_COUNT];
  logic [HW-1:0]              hdl_mem   [NODE_COUNT];
  logic [AW-1:0]              child_mem [NODE_COUNT];
  logic [AW-1:0]              sib_mem   [NODE_COUNT];
  logic [kstm_pkg::KEY_W-1:0] key_q;
  logic [HW-1:0]              hdl_q;
  logic [AW-1:0]              child_q;
  logic [AW-1:0]              sib_q;

  // pending result and output register
  kstm_pkg::status_t          res_status;
  logic [7:0]                 res_handler;
  logic [7:0]                 res_fchar;
  kstm_pkg::status_t          out_status;
  logic [7:0]                 out_handler;
  logic [7:0]                 out_fchar;
  logic                       out_valid;

  logic [AW-1:0] parent;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] new_idx;
  logic          child_ok;
  logic          link_new;
  logic          hit_leaf;
  logic          hdl_we;
  logic [AW-1:0] hdl_wa;
  logic          child_we;
  logic [AW-1:0] child_wa;
  logic [AW-1:0] child_wd;
  logic          sib_we;
  logic [AW-1:0] sib_wa;
  logic [AW-1:0] sib_wd;

  assign parent   = func_r ? mat_cur : ins_cur;
  assign rd_addr  = cmd.rd_parent ? parent : cur;
  assign new_idx  = nodes_used[AW-1:0];
  assign child_ok = (child_q != '0) && ({1'b0, child_q} < nodes_used);
  assign link_new = cmd.finish && (cmd.res == kstm_pkg::RES_INS_NEW);
  assign hit_leaf = (cmd.res == kstm_pkg::RES_MATCH_HIT) && !child_ok;

  assign stat.is_insert   = !func_r;
  assign stat.dropping    = dropping;
  assign stat.parent_root = (parent == '0);
  assign stat.cur_ok      = (cur != '0) && ({1'b0, cur} < nodes_used);
  assign stat.key_hit     = (key_q == key_r) || (func_r && (key_q == kstm_pkg::WILDCARD));
  assign stat.has_room    = (nodes_used < NODE_LIMIT);
  assign stat.out_free    = !out_valid || m_tready;

  // handler id reduced modulo HANDLER_COUNT
  if (HANDLER_COUNT >= 256) begin : g_hid_pass
    assign hid_mod = hid_r[HW-1:0];
  end else begin : g_hid_mod
    localparam int RECIP = 65536 / HANDLER_COUNT;
    localparam logic [15:0] RECIP_V = 16'(RECIP);
    localparam logic [8:0]  HC_V    = 9'(HANDLER_COUNT);
    logic [23:0] prod;
    logic [7:0]  quot;
    logic [16:0] back;
    logic [8:0]  rem1;
    // quotient from a floor reciprocal is exact or one short
    assign prod = 24'(in_hid) * 24'(RECIP_V);
    always_ff @(posedge clk) begin
      if (cmd.capture) begin
        quot <= prod[23:16];
      end
    end
    assign back    = 17'(quot) * 17'(HC_V);
    assign rem1    = {1'b0, hid_r} - back[8:0];
    assign hid_mod = (rem1 >= HC_V) ? HW'(rem1 - HC_V) : HW'(rem1);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      last_r <= in_last;
      key_r  <= in_key;
      hid_r  <= in_hid;
    end
  end

  // walk: start at the parent's first child, advance along siblings
  always_ff @(posedge clk) begin
    if (cmd.cur_from_root) begin
      cur  <= root_child;
      tail <= '0;
    end else if (cmd.cur_from_child) begin
      cur  <= child_q;
      tail <= '0;
    end else if (cmd.cur_from_sib) begin
      cur  <= sib_q;
      tail <= cur;
    end
  end

  // write ports
  always_comb begin
    hdl_we   = cmd.alloc || (cmd.finish && (cmd.res == kstm_pkg::RES_INS_FOUND));
    hdl_wa   = cmd.alloc ? new_idx : cur;
    child_we = cmd.alloc || (link_new && (tail == '0) && (ins_cur != '0));
    child_wa = cmd.alloc ? new_idx : ins_cur;
    child_wd = cmd.alloc ? '0 : new_idx;
    sib_we   = cmd.alloc || (link_new && (tail != '0));
    sib_wa   = cmd.alloc ? new_idx : tail;
    sib_wd   = cmd.alloc ? '0 : new_idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      key_mem[new_idx] <= key_r;
    end
    key_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (hdl_we) begin
      hdl_mem[hdl_wa] <= hid_mod;
    end
    hdl_q <= hdl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[child_wa] <= child_wd;
    end
    child_q <= child_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (sib_we) begin
      sib_mem[sib_wa] <= sib_wd;
    end
    sib_q <= sib_mem[rd_addr];
  end

  // cursors, fill count and drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_used <= (AW + 1)'(1);
      ins_cur    <= '0;
      mat_cur    <= '0;
      dropping   <= 1'b0;
      root_child <= '0;
    end else if (cmd.finish) begin
      case (cmd.res)
        kstm_pkg::RES_FULL: begin
          ins_cur  <= '0;
          dropping <= !last_r;
        end
        kstm_pkg::RES_INS_FOUND: begin
          ins_cur <= last_r ? '0 : cur;
        end
        kstm_pkg::RES_INS_NEW: begin
          ins_cur    <= last_r ? '0 : new_idx;
          nodes_used <= nodes_used + 1'b1;
          if ((tail == '0) && (ins_cur == '0)) begin
            root_child <= new_idx;
          end
        end
        kstm_pkg::RES_NOMATCH: begin
          mat_cur <= '0;
        end
        kstm_pkg::RES_MATCH_HIT: begin
          mat_cur <= child_ok ? cur : '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      // handler and character only on a leaf hit, zero otherwise
      res_handler <= hit_leaf ? 8'(hdl_q) : 8'd0;
      res_fchar   <= hit_leaf ? key_r : 8'd0;
      case (cmd.res)
        kstm_pkg::RES_FULL: begin
          res_status <= kstm_pkg::ST_FULL;
        end
        kstm_pkg::RES_INS_FOUND, kstm_pkg::RES_INS_NEW: begin
          res_status <= kstm_pkg::ST_INSERTED;
        end
        kstm_pkg::RES_MATCH_HIT: begin
          res_status <= child_ok ? kstm_pkg::ST_PENDING : kstm_pkg::ST_MATCHED;
        end
        default: begin
          res_status <= kstm_pkg::ST_NOMATCH;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status  <= res_status;
      out_handler <= res_handler;
      out_fchar   <= res_fchar;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_fchar, out_handler};
  assign m_tuser  = out_status;

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    (nodes_used != '0) && (nodes_used <= NODE_LIMIT))
    else $error("node fill count out of range");

  a_ins_cur: assert property (@(posedge clk) disable iff (rst)
    {1'b0, ins_cur} < nodes_used)
    else $error("insert cursor points past allocated nodes");

  a_mat_cur: assert property (@(posedge clk) disable iff (rst)
    {1'b0, mat_cur} < nodes_used)
    else $error("match cursor points past allocated nodes");

  a_grow: assert property (@(posedge clk) disable iff (rst)
    link_new |=> (nodes_used == $past(nodes_used) + 1'b1))
    else $error("new node did not advance the fill count");

  a_alloc_room: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |-> stat.has_room)
    else $error("allocation with a full node table");

endmodule

FILE: sim/key_sequence_trie_matcher_top_test.sv
`timescale 1ns / 1ps

module key_sequence_trie_matcher_top_test;

  localparam int NODE_COUNT    = 64;
  localparam int HANDLER_COUNT = 256;
  localparam int REQ_TARGET    = 1750;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int DRAIN_CYCLES  = 2 * NODE_COUNT + 40;
  localparam int HOLDOFF_LEN   = 400;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_MATCH  = 1'b1;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  typedef struct {
    logic       func;
    logic [7:0] key;
    logic [7:0] hid;
    logic       last;
  } key_req_t;

  typedef struct {
    kstm_pkg::status_t status;
    logic [7:0]        handler;
    logic [7:0]        fchar;
  } key_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;

  key_req_t    pending_reqs[$];
  key_result_t expected_results[$];
  key_req_t    cur_req;

  // trie mirror
  logic [7:0] trie_key [NODE_COUNT];
  logic [7:0] trie_hid [NODE_COUNT];
  int         trie_child [NODE_COUNT];
  int         trie_sib [NODE_COUNT];
  int         trie_used;
  int         match_at;
  int         insert_at;
  logic       insert_skip;

  int         n_mismatches = 0;
  int         results_seen = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         holdoff_left = 0;
  int         holdoff_at = 250;
  rx_mode_t   rx_mode = RX_OPEN;
  int         rx_mode_left = 0;
  int         rx_phase = 0;

  key_sequence_trie_matcher_top #(
    .NODE_COUNT   (NODE_COUNT),
    .HANDLER_COUNT(HANDLER_COUNT)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic link_live(int n);
    return n != 0 && n < trie_used && n < NODE_COUNT;
  endfunction

  // first child of parent taking ch; tail ends on the last sibling visited
  function automatic int walk_children(int parent, logic [7:0] ch, logic wild,
                                       output int tail);
    int n;
    int steps;
    n = trie_child[parent];
    tail = 0;
    for (steps = 0; steps < NODE_COUNT && link_live(n); steps++) begin
      if (trie_key[n] == ch || (wild && trie_key[n] == kstm_pkg::WILDCARD))
        return n;
      tail = n;
      n = trie_sib[n];
    end
    return 0;
  endfunction

  function automatic key_result_t predict_trie(key_req_t r);
    key_result_t res;
    int n;
    int tail;
    res.status  = kstm_pkg::ST_INSERTED;
    res.handler = '0;
    res.fchar   = '0;
    if (insert_at >= trie_used || insert_at >= NODE_COUNT) insert_at = 0;
    if (match_at >= trie_used || match_at >= NODE_COUNT) match_at = 0;
    if (r.func == OP_INSERT) begin
      if (insert_skip) begin
        res.status = kstm_pkg::ST_FULL;
        insert_at = 0;
        if (r.last) insert_skip = 1'b0;
      end else begin
        n = walk_children(insert_at, r.key, 1'b0, tail);
        if (n == 0 && trie_used < NODE_COUNT) begin
          n = trie_used;
          trie_used++;
          trie_key[n]   = r.key;
          trie_child[n] = 0;
          trie_sib[n]   = 0;
          if (tail == 0) trie_child[insert_at] = n;
          else trie_sib[tail] = n;
        end
        if (n == 0) begin
          res.status = kstm_pkg::ST_FULL;
          insert_at = 0;
          insert_skip = !r.last;
        end else begin
          res.status = kstm_pkg::ST_INSERTED;
          trie_hid[n] = 8'(r.hid % HANDLER_COUNT);
          insert_at = r.last ? 0 : n;
        end
      end
    end else begin
      n = walk_children(match_at, r.key, 1'b1, tail);
      if (n == 0) begin
        res.status = kstm_pkg::ST_NOMATCH;
        match_at = 0;
      end else if (link_live(trie_child[n])) begin
        res.status = kstm_pkg::ST_PENDING;
        match_at = n;
      end else begin
        res.status  = kstm_pkg::ST_MATCHED;
        res.handler = trie_hid[n];
        res.fchar   = r.key;
        match_at = 0;
      end
    end
    return res;
  endfunction

  task automatic add_req(logic func, logic [7:0] key, logic [7:0] hid, logic last);
    key_req_t r;
    r.func = func;
    r.key  = key;
    r.hid  = hid;
    r.last = last;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // mostly a small alphabet so that sequences share prefixes
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 4))
      0: return "a";
      1: return "b";
      2: return "c";
      3: return "d";
      default: return kstm_pkg::WILDCARD;
    endcase
  endfunction

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_results.insert(expected_results.size(), predict_trie(cur_req));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs[0];
          pending_reqs.delete(0);
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_req.hid, cur_req.key};
          s_tuser  <= cur_req.func;
          s_tlast  <= cur_req.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long hold-off of the receiver so that the block backs up
  always @(posedge clk) begin
    if (!rst) begin
      if (holdoff_left > 0) begin
        holdoff_left <= holdoff_left - 1;
      end else if (results_seen >= holdoff_at) begin
        holdoff_left <= HOLDOFF_LEN;
        holdoff_at <= holdoff_at + 900;
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    logic rdy;
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(32, 256);
    end else begin
      rx_mode_left--;
    end
    rx_phase++;
    case (rx_mode)
      RX_OPEN:     rdy = 1'b1;
      RX_COIN:     rdy = 1'($urandom_range(0, 1));
      RX_SPARSE:   rdy = ($urandom_range(0, 7) == 0);
      default:     rdy = (rx_phase % 4) != 0;
    endcase
    m_tready <= rdy && holdoff_left == 0;
  end

  // result checker
  always @(posedge clk) begin
    key_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        n_mismatches++;
        if (n_mismatches <= 10)
          $display("unexpected result: status %0d handler %02h char %02h",
                   m_tuser, m_tdata[7:0], m_tdata[15:8]);
      end else begin
        exp_res = expected_results[0];
        expected_results.delete(0);
        if (m_tuser !== exp_res.status || m_tdata[7:0] !== exp_res.handler ||
            m_tdata[15:8] !== exp_res.fchar) begin
          n_mismatches++;
          if (n_mismatches <= 10)
            $display("result %0d mismatch: status %0d/%0d handler %02h/%02h char %02h/%02h",
                     results_seen, m_tuser, exp_res.status, m_tdata[7:0], exp_res.handler,
                     m_tdata[15:8], exp_res.fchar);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int pick;
    int len;
    int k;
    int cut_at;
    logic [31:0] chars;
    logic [7:0] hid;
    logic [7:0] ch;
    logic broken;
    logic [31:0] seq_chars[$];
    int seq_lens[$];

    for (int i = 0; i < NODE_COUNT; i++) begin
      trie_key[i]   = '0;
      trie_hid[i]   = '0;
      trie_child[i] = 0;
      trie_sib[i]   = 0;
    end
    trie_used = 1;
    match_at = 0;
    insert_at = 0;
    insert_skip = 1'b0;

    // match on an empty trie
    add_req(OP_MATCH, "a", 8'hFF, 1'b1);
    add_req(OP_INSERT, "a", 8'h00, 1'b0);
    add_req(OP_INSERT, "b", 8'h00, 1'b1);
    // existing path takes the new handler; wildcard stored plainly
    add_req(OP_INSERT, "a", 8'hFF, 1'b0);
    add_req(OP_INSERT, kstm_pkg::WILDCARD, 8'hFF, 1'b1);
    add_req(OP_INSERT, 8'hFF, 8'h5A, 1'b1);
    add_req(OP_INSERT, 8'h00, 8'hA5, 1'b1);
    add_req(OP_INSERT, kstm_pkg::WILDCARD, 8'h11, 1'b1);
    add_req(OP_MATCH, "a", 8'h00, 1'b0);
    add_req(OP_MATCH, "b", 8'h00, 1'b0);
    add_req(OP_MATCH, "a", 8'h00, 1'b0);
    add_req(OP_MATCH, "z", 8'h00, 1'b0);
    add_req(OP_MATCH, "a", 8'h00, 1'b0);
    add_req(OP_MATCH, kstm_pkg::WILDCARD, 8'h00, 1'b0);
    add_req(OP_MATCH, 8'hFF, 8'h00, 1'b0);
    add_req(OP_MATCH, 8'h00, 8'h00, 1'b0);
    add_req(OP_MATCH, "q", 8'h00, 1'b0);
    // interleave both cursors
    add_req(OP_INSERT, "c", 8'h33, 1'b0);
    add_req(OP_MATCH, "a", 8'h00, 1'b0);
    add_req(OP_INSERT, "d", 8'h33, 1'b1);
    add_req(OP_MATCH, "b", 8'h00, 1'b0);
    add_req(OP_MATCH, "c", 8'h00, 1'b0);
    add_req(OP_MATCH, "d", 8'h00, 1'b0);

    while (pending_reqs.size() < REQ_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        len = $urandom_range(1, 4);
        hid = 8'($urandom_range(0, 255));
        broken = ($urandom_range(0, 7) == 0);
        chars = '0;
        for (int i = 0; i < len; i++) begin
          ch = pick_char();
          chars[8*i +: 8] = ch;
          add_req(OP_INSERT, ch, hid, !broken && i == len - 1);
        end
        if (!broken) begin
          seq_chars.insert(seq_chars.size(), chars);
          seq_lens.insert(seq_lens.size(), len);
        end
      end else if (pick < 90 && seq_lens.size() > 0) begin
        k = $urandom_range(0, seq_lens.size() - 1);
        len = seq_lens[k];
        chars = seq_chars[k];
        // now and then mutate one character or stop short
        if ($urandom_range(0, 4) == 0) chars[8*$urandom_range(0, len - 1) +: 8] = pick_char();
        cut_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : len;
        for (int i = 0; i < cut_at; i++)
          add_req(OP_MATCH, chars[8*i +: 8], 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else begin
        add_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", n_mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
